[rtl/fvnh_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the fractal value-noise height block.
// Used by every module under rtl; depends on nothing else.
package fvnh_pkg;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_SEED = 3'd0,
        REG_FREQ = 3'd1,
        REG_OCT  = 3'd2,
        REG_PERS = 3'd3,
        REG_LAC  = 3'd4,
        REG_BASE = 3'd5,
        REG_GAIN = 3'd6
    } t_reg_idx;

    // Reset values and clamp limits of the registers
    localparam logic [31:0] RST_SEED = 32'd0;
    localparam logic [31:0] RST_FREQ = 32'd1677722;
    localparam logic [3:0]  RST_OCT  = 4'd4;
    localparam logic [16:0] RST_PERS = 17'd32768;
    localparam logic [23:0] RST_LAC  = 24'd131072;
    localparam logic [31:0] RST_BASE = 32'd0;
    localparam logic [30:0] RST_GAIN = 31'd65536;
    localparam logic [31:0] MIN_FREQ = 32'd1678;
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [23:0] MIN_LAC  = 24'd65536;

    // Hash and smoothstep constants
    localparam logic [31:0] K_SEED    = 32'h9E3779B9;
    localparam logic [31:0] K_X       = 32'h85EBCA6B;
    localparam logic [31:0] K_Z       = 32'hC2B2AE35;
    localparam logic [31:0] K_M1      = 32'h7FEB352D;
    localparam logic [31:0] K_M2      = 32'h846CA68B;
    localparam logic [31:0] SEED_STEP = 32'd1013;
    localparam logic [17:0] SMOOTH_3  = 18'd196608;

    // Datapath widths and stage counts
    localparam int LANE_W    = 44;  // one octave term, noise Q.24 times amplitude Q1.16
    localparam int ACC_W     = 48;  // octave sum
    localparam int SUM_W     = 21;  // amplitude sum
    localparam int QBITS     = 25;  // magnitude bits of the normalized noise
    localparam int LANE_STG  = 7;
    localparam int NORM_STG  = 5 + QBITS;
    localparam int N_STG     = LANE_STG + NORM_STG;

    // Per-octave settings derived from the registers
    typedef struct packed {
        logic [31:0] freq;
        logic [31:0] seed;
        logic [16:0] amp;
    } t_oct_cfg;

    // Settings of the normalize and output stages
    typedef struct packed {
        logic [SUM_W-1:0] amp_sum;
        logic [30:0]      gain;
        logic [31:0]      base;
    } t_norm_cfg;

endpackage

[rtl/fvnh_cfg.sv]
`timescale 1ns / 1ps
// Register file and per-octave settings sweep.
// Depends on fvnh_pkg.
module fvnh_cfg
    import fvnh_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    output t_oct_cfg        o_oct_cfg [MAX_OCTAVES],
    output t_norm_cfg       o_norm_cfg,
    output logic            o_busy
);

    localparam int CW = $clog2(MAX_OCTAVES + 1);
    localparam logic [CW-1:0] LAST = CW'(MAX_OCTAVES - 1);

    logic [31:0] r_seed;
    logic [31:0] r_freq;
    logic [3:0]  r_oct;
    logic [16:0] r_pers;
    logic [23:0] r_lac;
    logic [31:0] r_base;
    logic [30:0] r_gain;

    logic          r_start;
    logic          r_busy;
    logic [CW-1:0] r_idx;

    logic [31:0]      r_cur_freq;
    logic [16:0]      r_cur_amp;
    logic [31:0]      r_cur_seed;
    logic [SUM_W-1:0] r_amp_sum;
    t_oct_cfg         r_tab [MAX_OCTAVES];

    logic [3:0]  w_oct;
    logic [55:0] w_fprod;
    logic [33:0] w_aprod;
    logic [31:0] n_cur_freq;
    logic [16:0] n_cur_amp;
    logic [16:0] w_amp_use;

    // Clamp the octave count written
    always_comb begin
        w_oct = i_cfg_data[3:0];
        if (w_oct == 4'd0) begin
            w_oct = 4'd1;
        end
        if (5'(w_oct) > 5'(MAX_OCTAVES)) begin
            w_oct = 4'(MAX_OCTAVES);
        end
    end

    // Register writes and sweep sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= RST_SEED;
            r_freq  <= RST_FREQ;
            r_oct   <= RST_OCT;
            r_pers  <= RST_PERS;
            r_lac   <= RST_LAC;
            r_base  <= RST_BASE;
            r_gain  <= RST_GAIN;
            r_start <= 1'b1;
            r_busy  <= 1'b1;
            r_idx   <= '0;
        end else if (i_cfg_wr) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SEED: r_seed <= i_cfg_data;
                REG_FREQ: r_freq <= (i_cfg_data < MIN_FREQ) ? MIN_FREQ : i_cfg_data;
                REG_OCT:  r_oct  <= w_oct;
                REG_PERS: r_pers <= (i_cfg_data[16:0] > ONE_Q16) ? ONE_Q16 : i_cfg_data[16:0];
                REG_LAC:  r_lac  <= (i_cfg_data[23:0] < MIN_LAC) ? MIN_LAC : i_cfg_data[23:0];
                REG_BASE: r_base <= i_cfg_data;
                REG_GAIN: r_gain <= i_cfg_data[30:0];
                default: ;
            endcase
            r_start <= 1'b1;
            r_busy  <= 1'b1;
        end else if (r_start) begin
            r_start <= 1'b0;
            r_idx   <= '0;
        end else if (r_busy) begin
            if (r_idx == LAST) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + CW'(1);
        end
    end

    // Advance frequency and amplitude by one octave
    assign w_fprod    = r_cur_freq * r_lac;
    assign n_cur_freq = (w_fprod[55:48] != 8'd0) ? 32'hFFFFFFFF : w_fprod[47:16];
    assign w_aprod    = r_cur_amp * r_pers;
    assign n_cur_amp  = w_aprod[32:16];
    assign w_amp_use  = (6'(r_idx) < 6'(r_oct)) ? r_cur_amp : 17'd0;

    always_ff @(posedge i_clk) begin
        if (r_start) begin
            r_cur_freq <= r_freq;
            r_cur_amp  <= ONE_Q16;
            r_cur_seed <= r_seed;
            r_amp_sum  <= '0;
        end else if (r_busy) begin
            r_cur_freq <= n_cur_freq;
            r_cur_amp  <= n_cur_amp;
            r_cur_seed <= r_cur_seed + SEED_STEP;
            r_amp_sum  <= r_amp_sum + SUM_W'(w_amp_use);
        end
    end

    // Store each octave's settings as the sweep passes it
    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_tab
        always_ff @(posedge i_clk) begin
            if (r_busy && !r_start && (r_idx == CW'(k))) begin
                r_tab[k].freq <= r_cur_freq;
                r_tab[k].seed <= r_cur_seed;
                r_tab[k].amp  <= w_amp_use;
            end
        end
        assign o_oct_cfg[k] = r_tab[k];
    end

    assign o_norm_cfg.amp_sum = r_amp_sum;
    assign o_norm_cfg.gain    = r_gain;
    assign o_norm_cfg.base    = r_base;
    assign o_busy             = r_busy;

endmodule

[rtl/fvnh_pipe_ctrl.sv]
`timescale 1ns / 1ps
// Valid bits and load enables of the pipeline; empty stages fill under a stall.
// Depends on fvnh_pkg.
module fvnh_pipe_ctrl
    import fvnh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic [N_STG-1:0] o_en,
    output logic             o_out_valid
);

    logic [N_STG-1:0] r_v;

    // A stage loads when it is empty or its successor loads
    for (genvar k = 0; k < N_STG - 1; k++) begin : g_en
        assign o_en[k] = !r_v[k] || o_en[k+1];
    end
    assign o_en[N_STG-1] = !r_v[N_STG-1] || i_out_ready;

    // Move valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < N_STG; k++) begin
                if (o_en[k]) begin
                    r_v[k] <= (k == 0) ? i_in_valid : r_v[(k + N_STG - 1) % N_STG];
                end
            end
        end
    end

    assign o_out_valid = r_v[N_STG-1];

endmodule

[rtl/fvnh_octave.sv]
`timescale 1ns / 1ps
// One octave lane: scale, floor, corner hashes, smoothstep lerp, amplitude weight.
// Depends on fvnh_pkg.
module fvnh_octave
    import fvnh_pkg::*;
(
    input  logic                       i_clk,
    input  logic [LANE_STG-1:0]        i_en,
    input  logic signed [31:0]         i_x_coord,
    input  logic signed [31:0]         i_z_coord,
    input  t_oct_cfg                   i_cfg,
    output logic signed [LANE_W-1:0]   o_term
);

    // Stage 0: scale the point
    logic signed [64:0] w_px, w_pz;
    logic signed [63:0] r_px, r_pz;

    assign w_px = $signed(i_x_coord) * $signed({1'b0, i_cfg.freq});
    assign w_pz = $signed(i_z_coord) * $signed({1'b0, i_cfg.freq});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_px <= w_px[63:0];
            r_pz <= w_pz[63:0];
        end
    end

    // Stage 1: floor to the cell, premultiply corners, square the fraction
    logic [31:0] w_x0, w_x1, w_z0, w_z1;
    logic [15:0] w_tx, w_tz;
    logic [31:0] r_mx0, r_mx1, r_mz0, r_mz1, r_sk, r_ttx, r_ttz;
    logic [15:0] r_tx, r_tz;

    assign w_x0 = {{8{r_px[63]}}, r_px[63:40]};
    assign w_z0 = {{8{r_pz[63]}}, r_pz[63:40]};
    assign w_x1 = w_x0 + 32'd1;
    assign w_z1 = w_z0 + 32'd1;
    assign w_tx = r_px[39:24];
    assign w_tz = r_pz[39:24];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_mx0 <= w_x0 * K_X;
            r_mx1 <= w_x1 * K_X;
            r_mz0 <= w_z0 * K_Z;
            r_mz1 <= w_z1 * K_Z;
            r_sk  <= i_cfg.seed ^ K_SEED;
            r_ttx <= w_tx * w_tx;
            r_ttz <= w_tz * w_tz;
            r_tx  <= w_tx;
            r_tz  <= w_tz;
        end
    end

    // Stage 2: combine hash inputs, first mix multiply, smoothstep weights
    // corner order: 0 = (x0,z0), 1 = (x1,z0), 2 = (x0,z1), 3 = (x1,z1)
    logic [31:0] w_g [4];
    logic [31:0] r_h [4];
    logic [49:0] w_wx, w_wz;
    logic [16:0] r_sx2, r_sz2;

    assign w_g[0] = r_sk ^ r_mx0 ^ r_mz0;
    assign w_g[1] = r_sk ^ r_mx1 ^ r_mz0;
    assign w_g[2] = r_sk ^ r_mx0 ^ r_mz1;
    assign w_g[3] = r_sk ^ r_mx1 ^ r_mz1;
    assign w_wx   = r_ttx * (SMOOTH_3 - {1'b0, r_tx, 1'b0});
    assign w_wz   = r_ttz * (SMOOTH_3 - {1'b0, r_tz, 1'b0});

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int c = 0; c < 4; c++) begin
                r_h[c] <= (w_g[c] ^ (w_g[c] >> 16)) * K_M1;
            end
            r_sx2 <= w_wx[48:32];
            r_sz2 <= w_wz[48:32];
        end
    end

    // Stage 3: second mix multiply
    logic [31:0] r_h2 [4];
    logic [16:0] r_sx3, r_sz3;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            for (int c = 0; c < 4; c++) begin
                r_h2[c] <= (r_h[c] ^ (r_h[c] >> 15)) * K_M2;
            end
            r_sx3 <= r_sx2;
            r_sz3 <= r_sz2;
        end
    end

    // Stage 4: corner values and the x lerp products
    logic [31:0]        w_f [4];
    logic signed [25:0] w_v [4];
    logic signed [26:0] w_dv0, w_dv1;
    logic signed [44:0] r_d0, r_d1;
    logic signed [25:0] r_v00, r_v01;
    logic [16:0]        r_sz4;

    for (genvar c = 0; c < 4; c++) begin : g_corner
        assign w_f[c] = r_h2[c] ^ (r_h2[c] >> 16);
        assign w_v[c] = $signed({1'b0, w_f[c][23:0], 1'b0}) - 26'sd16777216;
    end
    assign w_dv0 = w_v[1] - w_v[0];
    assign w_dv1 = w_v[3] - w_v[2];

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_d0  <= w_dv0 * $signed({1'b0, r_sx3});
            r_d1  <= w_dv1 * $signed({1'b0, r_sx3});
            r_v00 <= w_v[0];
            r_v01 <= w_v[2];
            r_sz4 <= r_sz3;
        end
    end

    // Stage 5: finish the x lerps, start the z lerp
    logic signed [25:0] w_r0, w_r1;
    logic signed [26:0] w_dr;
    logic signed [44:0] r_d;
    logic signed [25:0] r_r0;

    assign w_r0 = r_v00 + 26'(r_d0 >>> 16);
    assign w_r1 = r_v01 + 26'(r_d1 >>> 16);
    assign w_dr = w_r1 - w_r0;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_d  <= w_dr * $signed({1'b0, r_sz4});
            r_r0 <= w_r0;
        end
    end

    // Stage 6: finish the z lerp and weight by amplitude
    logic signed [25:0]       w_n;
    logic signed [LANE_W-1:0] r_term;

    assign w_n = r_r0 + 26'(r_d >>> 16);

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_term <= w_n * $signed({1'b0, i_cfg.amp});
        end
    end

    assign o_term = r_term;

endmodule

[rtl/fvnh_norm.sv]
`timescale 1ns / 1ps
// Octave sum tree, bit-per-stage divider, gain, offset and saturation.
// Depends on fvnh_pkg.
module fvnh_norm
    import fvnh_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                     i_clk,
    input  logic [NORM_STG-1:0]      i_en,
    input  logic signed [LANE_W-1:0] i_term [MAX_OCTAVES],
    input  t_norm_cfg                i_cfg,
    output logic [31:0]              o_height
);

    localparam int NG = (MAX_OCTAVES + 3) / 4;

    // Stage 0: partial sums over groups of four lanes
    logic signed [ACC_W-1:0] w_gs [NG];
    logic signed [ACC_W-1:0] r_gs [NG];

    for (genvar g = 0; g < NG; g++) begin : g_grp
        always_comb begin
            w_gs[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if (4 * g + j < MAX_OCTAVES) begin
                    w_gs[g] = w_gs[g] + ACC_W'(i_term[(4 * g + j) % MAX_OCTAVES]);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_gs[g] <= w_gs[g];
            end
        end
    end

    // Stage 1: total
    logic signed [ACC_W-1:0] w_tot, r_tot;

    always_comb begin
        w_tot = '0;
        for (int g = 0; g < NG; g++) begin
            w_tot = w_tot + r_gs[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_tot <= w_tot;
        end
    end

    // Stage 2 and on: sign and magnitude, then one quotient bit per stage
    logic [ACC_W-1:0] r_rem [QBITS+1];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic             r_neg [QBITS+1];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_neg[0] <= r_tot[ACC_W-1];
            r_rem[0] <= r_tot[ACC_W-1] ? ACC_W'(-r_tot) : ACC_W'(r_tot);
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QBITS; j++) begin : g_div
        localparam int SH = QBITS - 1 - j;
        logic [ACC_W-1:0] w_dsh;
        logic             w_ge;
        logic [QBITS-1:0] w_q;

        assign w_dsh = ACC_W'(i_cfg.amp_sum) << SH;
        assign w_ge  = r_rem[j] >= w_dsh;

        always_comb begin
            w_q     = r_q[j];
            w_q[SH] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[3+j]) begin
                r_rem[j+1] <= w_ge ? (r_rem[j] - w_dsh) : r_rem[j];
                r_q[j+1]   <= w_q;
                r_neg[j+1] <= r_neg[j];
            end
        end
    end

    // Apply the sign and the gain
    logic signed [QBITS:0] w_mag, w_norm;
    logic signed [57:0]    r_prod;

    assign w_mag  = $signed({1'b0, r_q[QBITS]});
    assign w_norm = r_neg[QBITS] ? -w_mag : w_mag;

    always_ff @(posedge i_clk) begin
        if (i_en[3+QBITS]) begin
            r_prod <= w_norm * $signed({1'b0, i_cfg.gain});
        end
    end

    // Offset and saturate into the output register
    logic signed [34:0] w_h;
    logic [31:0]        r_height;

    assign w_h = 35'($signed(i_cfg.base)) + 35'(r_prod >>> 24);

    always_ff @(posedge i_clk) begin
        if (i_en[4+QBITS]) begin
            if (w_h > 35'sd2147483647) begin
                r_height <= 32'h7FFFFFFF;
            end else if (w_h < -35'sd2147483648) begin
                r_height <= 32'h80000000;
            end else begin
                r_height <= w_h[31:0];
            end
        end
    end

    assign o_height = r_height;

endmodule

[rtl/fractal_value_noise_height.sv]
`timescale 1ns / 1ps
// Top level of the fractal value-noise height generator.
// Depends on fvnh_pkg, fvnh_cfg, fvnh_pipe_ctrl, fvnh_octave, fvnh_norm.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  input    | i_in_valid  / o_in_ready    | i_x_coord, i_z_coord (Q16.16)
//  output   | o_out_valid / i_out_ready   | o_height_out (Q16.16)
//  config   | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One beat enters per cycle while o_in_ready is high; each result then passes in order through
// 7 stages of octave lanes (all octaves run side by side), 2 summing stages,
// a sign stage, a 25-stage divider at one quotient bit per stage, gain and output stages.
// After reset and after every register write the octave settings are swept,
// and o_in_ready is low while the sweep runs; config beats are always taken.
// A stall fills empty stages first, so new beats are taken while a result waits until every stage is full.
module fractal_value_noise_height
    import fvnh_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_z_coord,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_height_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_oct_cfg                 w_oct_cfg [MAX_OCTAVES];
    t_norm_cfg                w_norm_cfg;
    logic                     w_busy;
    logic [N_STG-1:0]         w_en;
    logic signed [LANE_W-1:0] w_term [MAX_OCTAVES];
    logic [31:0]              w_height;

    // Registers and per-octave settings
    assign o_cfg_ready = 1'b1;

    fvnh_cfg #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_oct_cfg   (w_oct_cfg),
        .o_norm_cfg  (w_norm_cfg),
        .o_busy      (w_busy)
    );

    // Pipeline flow control
    fvnh_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid && !w_busy),
        .i_out_ready (i_out_ready),
        .o_en        (w_en),
        .o_out_valid (o_out_valid)
    );

    assign o_in_ready = w_en[0] && !w_busy;

    // One lane per octave
    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
        fvnh_octave u_oct (
            .i_clk     (i_clk),
            .i_en      (w_en[LANE_STG-1:0]),
            .i_x_coord (i_x_coord),
            .i_z_coord (i_z_coord),
            .i_cfg     (w_oct_cfg[k]),
            .o_term    (w_term[k])
        );
    end

    // Sum, normalize, scale
    fvnh_norm #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_norm (
        .i_clk    (i_clk),
        .i_en     (w_en[N_STG-1:LANE_STG]),
        .i_term   (w_term),
        .i_cfg    (w_norm_cfg),
        .o_height (w_height)
    );

    assign o_height_out = $signed(w_height);

endmodule
